// File: hw/rtl/sks_pkg.sv
// Shared types, codes and constants of the keyed store with expiry.
`timescale 1ns / 1ps
package sks_pkg;

  // Default geometry
  localparam int BucketsDef = 257;
  localparam int WaysDef    = 4;

  // Field widths
  localparam int KeyW    = 64;
  localparam int HandleW = 32;
  localparam int StampW  = 64;
  localparam int WindowW = 32;

  // Bucket hash: key reduced sixteen bits per step, a multiply and a subtract per step
  localparam int HashDigit = 16;
  localparam int HashSteps = 2 * (KeyW / HashDigit);
  localparam int HashCntW  = $clog2(HashSteps);

  // Action codes
  localparam logic [2:0] ACT_SAVE   = 3'd0;
  localparam logic [2:0] ACT_GET    = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_SETACT = 3'd3;
  localparam logic [2:0] ACT_EXPIRE = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Configuration register addresses
  localparam logic [2:0] ADDR_WINDOW = 3'd0;
  localparam logic [WindowW-1:0] WindowRst = 32'd10000;

  // One slot of the store
  typedef struct packed {
    logic               valid;
    logic               active;
    logic [StampW-1:0]  stamp;
    logic [HandleW-1:0] handle;
    logic [KeyW-1:0]    key;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic hash_step;
    logic probe_rd;
    logic probe_chk;
    logic apply;
    logic sweep_rd;
    logic sweep_chk;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic hash_last;
    logic way_last;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/socket_keyed_store_with_expiry_top.sv
// Top level: keyed store with aging expiry, APB window register, checks.
//
// Input channel (in_valid/in_stall) takes one transaction: action, key,
// handle_in, active, now_count, queue_emptied. Output channel
// (out_valid/out_stall) returns one transaction per input: status, found,
// handle_out. Entry lives in bucket key mod BUCKETS, one of WAYS slots.
// Save, get, delete and set-active reduce the key to its bucket sixteen bits
// per step, a reciprocal multiply and a subtract per step, then each way is
// read and checked through the single memory read port. Expire reads every
// slot and writes back those that expire or take a stamp.
// One transaction is in flight at a time; the next is taken
// while a finished result still waits in the output register.
// After reset a clearing pass over every slot empties the slot memory;
// in_stall is high meanwhile. The window register is written over
// APB at address 0 and resets to 10000. When the receiver stalls, the
// result holds and the block finishes the next transaction up to its
// result, then waits.
`timescale 1ns / 1ps
module socket_keyed_store_with_expiry_top #(
  parameter int BUCKETS = sks_pkg::BucketsDef,
  parameter int WAYS    = sks_pkg::WaysDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    action,
  input  logic [sks_pkg::KeyW-1:0]      key,
  input  logic [sks_pkg::HandleW-1:0]   handle_in,
  input  logic                          active,
  input  logic [sks_pkg::StampW-1:0]    now_count,
  input  logic                          queue_emptied,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic                          found,
  output logic [sks_pkg::HandleW-1:0]   handle_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [sks_pkg::WindowW-1:0] window;
  sks_pkg::cmd_t  cmd;
  sks_pkg::stat_t stat;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= sks_pkg::WindowRst;
    end else if (psel && penable && pwrite && paddr == sks_pkg::ADDR_WINDOW) begin
      window <= pwdata;
    end
  end
  assign prdata = (paddr == sks_pkg::ADDR_WINDOW) ? window : 32'd0;

  sks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sks_datapath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .key           (key),
    .handle_in     (handle_in),
    .active        (active),
    .now_count     (now_count),
    .queue_emptied (queue_emptied),
    .window        (window),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .found         (found),
    .handle_out    (handle_out)
  );

  // A hit is always reported with status ok
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == sks_pkg::ST_OK)
    else $error("found set with non-ok status");

  // Handle is zero unless the key was found
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> handle_out == '0)
    else $error("handle_out nonzero without a hit");

  // The clearing pass holds off input right after reset
  a_clear_stall: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("input accepted during clearing pass");

  // Only one clear, hash, probe, apply or sweep step is commanded at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_wr, cmd.hash_step, cmd.probe_rd, cmd.probe_chk,
              cmd.apply, cmd.sweep_rd, cmd.sweep_chk}))
    else $error("conflicting datapath commands");

endmodule

// File: hw/rtl/sks_ctrl.sv
// Controller state machine: sequences clear, hash, probe, apply and sweep.
`timescale 1ns / 1ps
module sks_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [2:0]     action,
  input  sks_pkg::stat_t stat,
  output logic           in_stall,
  output sks_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PRD, S_PCHK, S_APPLY, S_SRD, S_SCHK, S_DONE
  } state_t;

  state_t state;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: if (stat.clear_last) state <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            if (action == sks_pkg::ACT_EXPIRE) state <= S_SRD;
            else if (action inside {sks_pkg::ACT_SAVE, sks_pkg::ACT_GET,
                                    sks_pkg::ACT_DELETE, sks_pkg::ACT_SETACT})
              state <= S_HASH;
            else state <= S_DONE;
          end
        end
        S_HASH:  if (stat.hash_last) state <= S_PRD;
        S_PRD:   state <= S_PCHK;
        S_PCHK:  state <= stat.way_last ? S_APPLY : S_PRD;
        S_APPLY: state <= S_DONE;
        S_SRD:   state <= S_SCHK;
        S_SCHK:  state <= stat.sweep_last ? S_DONE : S_SRD;
        S_DONE:  if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Commands decoded from state
  always_comb begin
    cmd           = '0;
    cmd.clear_wr  = (state == S_CLEAR);
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.hash_step = (state == S_HASH);
    cmd.probe_rd  = (state == S_PRD);
    cmd.probe_chk = (state == S_PCHK);
    cmd.apply     = (state == S_APPLY);
    cmd.sweep_rd  = (state == S_SRD);
    cmd.sweep_chk = (state == S_SCHK);
    cmd.finish    = (state == S_DONE) && stat.out_free;
  end

  assign in_stall = (state != S_IDLE);

endmodule

// File: hw/rtl/sks_datapath.sv
// Datapath: slot memory, bucket hash, probe and sweep logic, result register.
`timescale 1ns / 1ps
module sks_datapath #(
  parameter int BUCKETS = sks_pkg::BucketsDef,
  parameter int WAYS    = sks_pkg::WaysDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sks_pkg::cmd_t                 cmd,
  output sks_pkg::stat_t                stat,
  input  logic [2:0]                    action,
  input  logic [sks_pkg::KeyW-1:0]      key,
  input  logic [sks_pkg::HandleW-1:0]   handle_in,
  input  logic                          active,
  input  logic [sks_pkg::StampW-1:0]    now_count,
  input  logic                          queue_emptied,
  input  logic [sks_pkg::WindowW-1:0]   window,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic                          found,
  output logic [sks_pkg::HandleW-1:0]   handle_out
);

  localparam int Slots = BUCKETS * WAYS;
  localparam int SW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int RW    = $clog2(BUCKETS + 1);
  localparam int WW    = $clog2(WAYS + 1);

  // Hash step: {rem, chunk} mod BUCKETS by reciprocal multiplication
  localparam int ChunkW = sks_pkg::HashDigit;
  localparam int TW     = RW + ChunkW;
  localparam int BL     = $clog2(BUCKETS);
  localparam int RecipS = TW + BL;
  localparam int MW     = TW + 1;
  localparam int PW     = TW + MW;
  localparam int QW     = TW + 1 - BL;
  localparam logic [63:0] RecipM =
    ((64'd1 << RecipS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

  // Latched transaction
  logic [2:0]                  op_q;
  logic [sks_pkg::KeyW-1:0]    key_q, ksh;
  logic [sks_pkg::HandleW-1:0] handle_q;
  logic                        act_q, emptied_q;
  logic [sks_pkg::StampW-1:0]  now_q;

  // Control counters
  logic [sks_pkg::HashCntW-1:0] hcnt;
  logic [RW-1:0]                rem;
  logic [WW-1:0]                way;
  logic [SW-1:0]                scnt;

  // Hash pipeline
  logic [TW-1:0] hash_in, hash_t, hash_qb, hash_r;
  logic [PW-1:0] hash_p;
  logic [QW-1:0] hash_q;

  // Probe bookkeeping
  logic                  hit, free_ok;
  logic [SW-1:0]         hit_slot, free_slot, paddr_cur;
  sks_pkg::entry_t       hit_word, rdata, wdata;
  logic                  we;
  logic [SW-1:0]         waddr, raddr;
  logic                  re;

  // Result
  logic [1:0]                  res_status;
  logic                        res_found;
  logic [sks_pkg::HandleW-1:0] res_handle;

  sks_pkg::entry_t mem [Slots];

  // Quotient from the registered product, remainder by one subtract
  assign hash_in = {rem, ksh[sks_pkg::KeyW-1 -: ChunkW]};
  assign hash_q  = hash_p[PW-1 -: QW];
  assign hash_qb = TW'(hash_q * BUCKETS);
  assign hash_r  = hash_t - hash_qb;

  assign paddr_cur = SW'(rem * WAYS) + SW'(way);

  // Status toward the controller
  assign stat.clear_last = (scnt == SW'(Slots - 1));
  assign stat.sweep_last = (scnt == SW'(Slots - 1));
  assign stat.hash_last  = (hcnt == sks_pkg::HashCntW'(sks_pkg::HashSteps - 1));
  assign stat.way_last   = (way == WW'(WAYS - 1));
  assign stat.out_free   = !out_valid || !out_stall;

  // Age test: stamp + window < now without wraparound
  logic too_old;
  assign too_old = (rdata.stamp < now_q) &&
                   ((now_q - rdata.stamp) > {32'd0, window});

  // Memory write and read selection
  always_comb begin
    we    = 1'b0;
    waddr = scnt;
    wdata = '0;
    re    = cmd.probe_rd || cmd.sweep_rd;
    raddr = cmd.probe_rd ? paddr_cur : scnt;
    if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (cmd.apply) begin
      case (op_q)
        sks_pkg::ACT_SAVE: begin
          we    = !hit && free_ok;
          waddr = free_slot;
          wdata = '{valid: 1'b1, active: 1'b1, stamp: '0, handle: handle_q, key: key_q};
        end
        sks_pkg::ACT_DELETE: begin
          we          = hit;
          waddr       = hit_slot;
          wdata       = hit_word;
          wdata.valid = 1'b0;
        end
        sks_pkg::ACT_SETACT: begin
          we           = hit;
          waddr        = hit_slot;
          wdata        = hit_word;
          wdata.active = act_q;
        end
        default: we = 1'b0;
      endcase
    end else if (cmd.sweep_chk) begin
      wdata = rdata;
      if (rdata.valid) begin
        if (rdata.stamp != '0 && (emptied_q || too_old)) begin
          we          = 1'b1;
          wdata.valid = 1'b0;
        end else if (!rdata.active && rdata.stamp == '0) begin
          we          = 1'b1;
          wdata.stamp = now_q;
        end
      end
    end
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scnt <= '0;
      hcnt <= '0;
      way  <= '0;
    end else begin
      if (cmd.clear_wr || cmd.sweep_chk)
        scnt <= stat.sweep_last ? '0 : scnt + SW'(1);
      if (cmd.load) hcnt <= '0;
      else if (cmd.hash_step) hcnt <= hcnt + sks_pkg::HashCntW'(1);
      if (cmd.load) way <= '0;
      else if (cmd.probe_chk) way <= stat.way_last ? '0 : way + WW'(1);
    end
  end

  // Transaction capture, hash and probe registers
  logic [SW-1:0] chk_addr;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= action;
      key_q     <= key;
      ksh       <= key;
      handle_q  <= handle_in;
      act_q     <= active;
      now_q     <= now_count;
      emptied_q <= queue_emptied;
      rem       <= '0;
      hit       <= 1'b0;
      free_ok   <= 1'b0;
    end
    // Even cycle multiplies by the reciprocal, odd cycle subtracts
    if (cmd.hash_step) begin
      if (!hcnt[0]) begin
        hash_t <= hash_in;
        hash_p <= {{MW{1'b0}}, hash_in} * {{TW{1'b0}}, RecipM[MW-1:0]};
        ksh    <= ksh << ChunkW;
      end else begin
        rem <= hash_r[RW-1:0];
      end
    end
    if (cmd.probe_rd) chk_addr <= paddr_cur;
    if (cmd.probe_chk) begin
      if (rdata.valid && rdata.key == key_q && !hit) begin
        hit      <= 1'b1;
        hit_slot <= chk_addr;
        hit_word <= rdata;
      end
      if (!rdata.valid && !free_ok) begin
        free_ok   <= 1'b1;
        free_slot <= chk_addr;
      end
    end
  end

  // Result of the transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= sks_pkg::ST_OK;
      res_found  <= 1'b0;
      res_handle <= '0;
    end else if (cmd.apply) begin
      case (op_q)
        sks_pkg::ACT_SAVE:
          res_status <= hit ? sks_pkg::ST_DUP :
                        (free_ok ? sks_pkg::ST_OK : sks_pkg::ST_FULL);
        sks_pkg::ACT_GET: begin
          res_status <= hit ? sks_pkg::ST_OK : sks_pkg::ST_MISS;
          res_found  <= hit;
          res_handle <= hit ? hit_word.handle : '0;
        end
        sks_pkg::ACT_SETACT: res_status <= hit ? sks_pkg::ST_OK : sks_pkg::ST_MISS;
        default: res_status <= sks_pkg::ST_OK;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status     <= res_status;
      found      <= res_found;
      handle_out <= res_handle;
    end
  end

endmodule

// File: test/tb.sv
// Testbench for the keyed store with aging expiry: directed and random checks.
`timescale 1ns / 1ps
module tb;
  import sks_pkg::*;

  localparam int NBUCK = BucketsDef;
  localparam int NWAYS = WaysDef;
  localparam int NSLOT = NBUCK * NWAYS;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [2:0] action;
  logic [KeyW-1:0] key;
  logic [HandleW-1:0] handle_in;
  logic active;
  logic [StampW-1:0] now_count;
  logic queue_emptied;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic found;
  logic [HandleW-1:0] handle_out;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  socket_keyed_store_with_expiry_top uut (.*);

  typedef struct packed {
    logic [1:0] status;
    logic found;
    logic [HandleW-1:0] handle;
  } reply_t;

  // Shadow copy of the store
  logic [WindowW-1:0] win_shadow;
  bit sh_valid[NSLOT];
  logic [KeyW-1:0] sh_key[NSLOT];
  logic [HandleW-1:0] sh_handle[NSLOT];
  logic [StampW-1:0] sh_stamp[NSLOT];
  bit sh_active[NSLOT];

  reply_t pending_replies[$];
  int errors = 0;
  longint cycles = 0;
  logic [KeyW-1:0] key_pool[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int find_slot(logic [KeyW-1:0] k);
    int base;
    base = int'(k % NBUCK) * NWAYS;
    for (int w = 0; w < NWAYS; w++)
      if (sh_valid[base + w] && sh_key[base + w] == k) return base + w;
    return -1;
  endfunction

  // Predict one reply and update the shadow store
  function automatic reply_t predict_reply(logic [2:0] act, logic [KeyW-1:0] k,
                                           logic [HandleW-1:0] h, logic a,
                                           logic [StampW-1:0] now, logic emp);
    reply_t r;
    int s, base;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_SAVE: begin
        if (find_slot(k) >= 0) r.status = ST_DUP;
        else begin
          base = int'(k % NBUCK) * NWAYS;
          r.status = ST_FULL;
          for (int w = 0; w < NWAYS; w++) begin
            if (!sh_valid[base + w]) begin
              sh_valid[base + w] = 1;
              sh_key[base + w] = k;
              sh_handle[base + w] = h;
              sh_stamp[base + w] = '0;
              sh_active[base + w] = 1;
              r.status = ST_OK;
              break;
            end
          end
        end
      end
      ACT_GET: begin
        s = find_slot(k);
        if (s >= 0) begin
          r.found = 1;
          r.handle = sh_handle[s];
        end else r.status = ST_MISS;
      end
      ACT_DELETE: begin
        s = find_slot(k);
        if (s >= 0) sh_valid[s] = 0;
      end
      ACT_SETACT: begin
        s = find_slot(k);
        if (s >= 0) sh_active[s] = a;
        else r.status = ST_MISS;
      end
      ACT_EXPIRE: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!sh_valid[i]) continue;
          if (sh_stamp[i] != 0 && (emp || (sh_stamp[i] < now &&
              (now - sh_stamp[i]) > {32'd0, win_shadow})))
            sh_valid[i] = 0;
          else if (!sh_active[i] && sh_stamp[i] == 0)
            sh_stamp[i] = now;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: random stall, check each transaction
  always @(posedge clk) begin
    reply_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result status=%0d", status);
        errors++;
      end else begin
        e = pending_replies.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
        if (found !== e.found) begin
          $error("found expected %0d actual %0d", e.found, found);
          errors++;
        end
        if (handle_out !== e.handle) begin
          $error("handle_out expected %h actual %h", e.handle, handle_out);
          errors++;
        end
      end
    end
  end

  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst || stall_mode == 0) out_stall <= 0;
    else if ($urandom_range(99) < 8) out_stall <= ($urandom_range(9) == 0) ?
        ($urandom_range(1) == 1) : 1'b1;
    else out_stall <= ($urandom_range(3) == 0);
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(2, 1);
    repeat (n) @(posedge clk);
  endtask

  // Send one transaction and record its expected reply
  task automatic send_item(logic [2:0] act, logic [KeyW-1:0] k,
                           logic [HandleW-1:0] h, logic a,
                           logic [StampW-1:0] now, logic emp, bit gaps = 1);
    in_valid <= 1;
    action <= act;
    key <= k;
    handle_in <= h;
    active <= a;
    now_count <= now;
    queue_emptied <= emp;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(predict_reply(act, k, h, a, now, emp));
    if (gaps && $urandom_range(2) == 0) begin
      in_valid <= 0;
      idle_gap();
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2 * NSLOT + 40) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_WINDOW; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    win_shadow = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Keys that share one bucket, to fill it past its ways
  function automatic logic [KeyW-1:0] bucket_key(int b, int n);
    return 64'(b) + 64'(NBUCK) * 64'(n);
  endfunction

  task automatic test_directed();
    send_item(ACT_GET, 64'd0, 0, 0, 0, 0);
    send_item(ACT_SETACT, '1, 0, 1, 0, 0);
    for (int i = 0; i < NWAYS + 1; i++)
      send_item(ACT_SAVE, bucket_key(5, i), 32'hA000_0000 + i, 0, 0, 0);
    send_item(ACT_SAVE, bucket_key(5, 1), 32'h1234, 0, 0, 0);
    send_item(ACT_GET, bucket_key(5, 2), 0, 0, 0, 0);
    send_item(ACT_SAVE, '1, '1, 1, '1, 1);
    send_item(ACT_GET, '1, 0, 0, 0, 0);
    send_item(ACT_DELETE, bucket_key(5, 0), 0, 0, 0, 0);
    send_item(ACT_DELETE, bucket_key(5, 0), 0, 0, 0, 0);
    send_item(ACT_SAVE, bucket_key(5, 9), 32'h55, 0, 0, 0);
    send_item(ACT_SETACT, bucket_key(5, 1), 0, 0, 0, 0);
    send_item(ACT_SETACT, '1, 0, 0, 0, 0);
    // now_count zero leaves inactive entries unstamped
    send_item(ACT_EXPIRE, 0, 0, 0, 64'd0, 0);
    send_item(ACT_EXPIRE, 0, 0, 0, 64'd100, 0);
    send_item(ACT_SETACT, bucket_key(5, 1), 0, 1, 0, 0);
    send_item(ACT_EXPIRE, 0, 0, 0, 64'd10100, 0);
    send_item(ACT_EXPIRE, 0, 0, 0, 64'd10101, 0);
    send_item(ACT_EXPIRE, 0, 0, 0, '1, 1);
    send_item(3'd5, 1, 1, 1, 1, 1);
    send_item(3'd7, '1, '1, 1, '1, 1);
    send_item(ACT_GET, bucket_key(5, 1), 0, 0, 0, 0);
    drain();
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(9) < 8)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    return rand64();
  endfunction

  // Mostly live keys so gets and deletes hit; few sweeps since each is long
  task automatic test_random(int n, logic [StampW-1:0] base_now);
    logic [2:0] act;
    logic [KeyW-1:0] k;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        act = ACT_SAVE;
        k = ($urandom_range(3) == 0) ? bucket_key($urandom_range(3), $urandom_range(7))
                                     : rand64();
        key_pool.push_back(k);
      end else if (r < 55) begin act = ACT_GET; k = pick_key(); end
      else if (r < 70) begin act = ACT_DELETE; k = pick_key(); end
      else if (r < 90) begin act = ACT_SETACT; k = pick_key(); end
      else if (r < 96) begin act = ACT_EXPIRE; k = rand64(); end
      else begin act = 3'($urandom_range(7, 5)); k = rand64(); end
      send_item(act, k, $urandom(), 1'($urandom()),
                ($urandom_range(3) == 0) ? rand64()
                                         : base_now + 64'(i) * 64'($urandom_range(50)),
                ($urandom_range(15) == 0), stall_mode != 2);
    end
    drain();
  endtask

  // Sender holds off until all results are back
  task automatic test_backpressure_pause();
    stall_mode = 1;
    for (int i = 0; i < 6; i++)
      send_item(ACT_SAVE, rand64(), $urandom(), 0, 0, 0, 0);
    in_valid <= 0;
    while (pending_replies.size() != 0) @(posedge clk);
    send_item(ACT_GET, pick_key(), 0, 0, 0, 0);
    drain();
  endtask

  initial begin
    rst = 1;
    in_valid = 0; action = '0; key = '0; handle_in = '0; active = 0;
    now_count = '0; queue_emptied = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    win_shadow = WindowRst;
    foreach (sh_valid[i]) begin
      sh_valid[i] = 0; sh_key[i] = '0; sh_handle[i] = '0;
      sh_stamp[i] = '0; sh_active[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_directed();
    write_window(32'd1);
    stall_mode = 1;
    test_random(300, 64'd1000);
    write_window('1);
    test_random(300, 64'hFFFF_FFFF_0000_0000);
    write_window(32'd500);
    stall_mode = 2;
    test_random(300, 64'd0);
    test_backpressure_pause();
    write_window(32'd20);
    stall_mode = 1;
    test_random(300, 64'd5);

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
